// ----- rtl/pidsc_pkg.sv -----
// Shared types, constants and helper functions for the speed PID controller.
package pidsc_pkg;

    localparam int W_WORD      = 64;
    localparam int GAIN_SCALE  = 1000;
    localparam int K_MILLI     = 1000;
    localparam int K_IDIV      = GAIN_SCALE * 1000;
    localparam int W_EI        = 48;
    localparam int W_DF        = 40;
    localparam int W_SPEED     = 17;
    localparam int W_DUTY      = 16;
    localparam int W_PTERM     = 25;

    typedef logic signed [W_WORD-1:0] t_word;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_FF_DUTY   = 3'd3,
        CFG_FF_SPEED  = 3'd4,
        CFG_OUT_MIN   = 3'd5,
        CFG_OUT_MAX   = 3'd6,
        CFG_PERIOD    = 3'd7
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } t_state;

    // Arithmetic steps of one update, in issue order
    typedef enum logic [3:0] {
        ST_LIM_MUL,
        ST_LIM_DIV,
        ST_FF_MUL,
        ST_FF_DIV,
        ST_P_MUL,
        ST_P_DIV,
        ST_R_MUL,
        ST_R_DIV,
        ST_D_MUL,
        ST_D_DIV,
        ST_F_DIV,
        ST_E_MUL,
        ST_CI_MUL,
        ST_CI_DIV,
        ST_I_MUL,
        ST_I_DIV
    } t_step;

    // Request to and status from the serial arithmetic unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_su_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_su_rsp;

    // Clamp a wide value to the output limits
    function automatic logic signed [W_DUTY-1:0] clamp_out(
        input t_word v,
        input logic signed [W_DUTY-1:0] lo,
        input logic signed [W_DUTY-1:0] hi
    );
        logic signed [W_DUTY-1:0] r;
        if (v < W_WORD'(lo)) begin
            r = lo;
        end else if (v > W_WORD'(hi)) begin
            r = hi;
        end else begin
            r = v[W_DUTY-1:0];
        end
        return r;
    endfunction

    // Clamp a wide value to +-lim
    function automatic t_word clamp_sym(input t_word v, input t_word lim);
        t_word r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/pidsc_in_if.sv -----
// Input channel: one control update or clear transaction.
interface pidsc_in_if;
    import pidsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      action;
    logic signed [W_SPEED-1:0] target_speed;
    logic signed [W_SPEED-1:0] measured_speed;

    modport source (output valid, output action, output target_speed,
                    output measured_speed, input ready);
    modport sink   (input valid, input action, input target_speed,
                    input measured_speed, output ready);
endinterface

// ----- rtl/pidsc_out_if.sv -----
// Output channel: one duty result transaction.
interface pidsc_out_if;
    import pidsc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [W_DUTY-1:0] duty;

    modport source (output valid, output duty, input ready);
    modport sink   (input valid, input duty, output ready);
endinterface

// ----- rtl/pidsc_serial_unit.sv -----
// Bit-serial signed multiplier and truncating divider, one bit per cycle.
module pidsc_serial_unit
    import pidsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_su_req i_req,
    input  t_word   i_a,
    input  t_word   i_b,
    output t_su_rsp o_rsp,
    output t_word   o_result
);

    localparam int W_CNT = $clog2(W_WORD);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_div,  n_div;
    logic              r_neg,  n_neg;
    logic [W_CNT-1:0]  r_cnt,  n_cnt;
    logic [W_WORD-1:0] r_x, n_x;
    logic [W_WORD-1:0] r_y, n_y;
    logic [W_WORD-1:0] r_acc, n_acc;

    logic [W_WORD-1:0] w_mag_a, w_mag_b, w_trial, w_val;

    assign w_mag_a = i_a[W_WORD-1] ? W_WORD'(-i_a) : W_WORD'(i_a);
    assign w_mag_b = i_b[W_WORD-1] ? W_WORD'(-i_b) : W_WORD'(i_b);
    assign w_trial = {r_acc[W_WORD-2:0], r_y[W_WORD-1]};

    // Load on start, then one bit of product or quotient per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_div  = r_div;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_div  = i_req.is_div;
            n_neg  = i_a[W_WORD-1] ^ i_b[W_WORD-1];
            n_cnt  = '0;
            n_acc  = '0;
            n_x    = i_req.is_div ? w_mag_b : w_mag_a;
            n_y    = i_req.is_div ? w_mag_a : w_mag_b;
        end else if (r_busy) begin
            if (r_div) begin
                if (w_trial >= r_x) begin
                    n_acc = w_trial - r_x;
                    n_y   = {r_y[W_WORD-2:0], 1'b1};
                end else begin
                    n_acc = w_trial;
                    n_y   = {r_y[W_WORD-2:0], 1'b0};
                end
            end else begin
                n_acc = r_y[0] ? (r_acc + r_x) : r_acc;
                n_x   = {r_x[W_WORD-2:0], 1'b0};
                n_y   = {1'b0, r_y[W_WORD-1:1]};
            end
            n_cnt = r_cnt + W_CNT'(1);
            if (r_cnt == {W_CNT{1'b1}}) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_div <= n_div;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    // Apply the sign of the result
    assign w_val       = r_div ? r_y : r_acc;
    assign o_result    = r_neg ? -t_word'(w_val) : t_word'(w_val);
    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;

endmodule

// ----- rtl/pid_speed_controller_ff_antiwindup_unit.sv -----
// Speed PID controller with feed-forward and conditional-integration anti-windup.
// Each update transaction runs sixteen multiply or divide steps through one bit-serial
// arithmetic unit that retires one bit per cycle over 64-bit operands. The first sample
// after reset or a clear skips the five derivative steps. A clear transaction returns
// duty 0. Inputs are taken only while no update is running; the finished duty waits in
// an output register so the next transaction can be accepted.
module pid_speed_controller_ff_antiwindup_unit
    import pidsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    pidsc_in_if.sink             i_item,
    pidsc_out_if.source          o_result
);

    // Configuration registers
    logic [15:0]              r_gain_p, r_gain_i, r_gain_d, r_ff_speed;
    logic [14:0]              r_ff_duty;
    logic signed [15:0]       r_out_min, r_out_max;
    logic [9:0]               r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_ff_duty  <= '0;
            r_ff_speed <= 16'd1;
            r_out_min  <= '0;
            r_out_max  <= '0;
            r_period   <= 10'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:   r_gain_p   <= i_cfg_data;
                CFG_GAIN_I:   r_gain_i   <= i_cfg_data;
                CFG_GAIN_D:   r_gain_d   <= i_cfg_data;
                CFG_FF_DUTY:  r_ff_duty  <= i_cfg_data[14:0];
                CFG_FF_SPEED: r_ff_speed <= i_cfg_data;
                CFG_OUT_MIN:  r_out_min  <= i_cfg_data;
                CFG_OUT_MAX:  r_out_max  <= i_cfg_data;
                CFG_PERIOD:   r_period   <= i_cfg_data[9:0];
                default:      r_gain_p   <= r_gain_p;
            endcase
        end
    end

    // Sequencer and controller state
    t_state                       r_state, n_state;
    t_step                        r_step, n_step;
    logic signed [W_SPEED-1:0]    r_tgt, n_tgt;
    logic signed [W_SPEED-1:0]    r_meas, n_meas;
    logic signed [W_SPEED:0]      r_err, n_err;
    logic signed [W_SPEED-1:0]    r_last, n_last;
    logic                         r_have_last, n_have_last;
    logic signed [W_EI-1:0]       r_ei, n_ei;
    logic signed [W_DF-1:0]       r_df, n_df;
    logic signed [W_EI-1:0]       r_lim, n_lim;
    logic signed [W_EI-1:0]       r_cand, n_cand;
    logic signed [W_DUTY-1:0]     r_ff, n_ff;
    logic signed [W_PTERM-1:0]    r_p, n_p;
    t_word                        r_t, n_t;
    logic signed [W_DUTY-1:0]     r_res, n_res;
    logic                         r_ovalid, n_ovalid;
    logic signed [W_DUTY-1:0]     r_duty, n_duty;

    t_su_req                      w_req;
    t_su_rsp                      w_rsp;
    logic                         w_start, w_is_div;
    t_word                        w_a, w_b, w_q;

    logic signed [W_DUTY-1:0]     w_lo, w_hi;
    t_word                        w_span, w_per, w_ffmax, w_gi, w_sum, w_lim_new;
    t_word                        w_ei_rc, w_cand_cl;
    logic                         w_accept;

    // Effective limits and guarded divisors
    assign w_lo     = (r_out_min <= r_out_max) ? r_out_min : r_out_max;
    assign w_hi     = (r_out_min <= r_out_max) ? r_out_max : r_out_min;
    assign w_span   = W_WORD'(w_hi) - W_WORD'(w_lo);
    assign w_per    = (r_period == '0) ? t_word'(1) : t_word'({54'd0, r_period});
    assign w_ffmax  = (r_ff_speed == '0) ? t_word'(1) : t_word'({48'd0, r_ff_speed});
    assign w_gi     = t_word'({48'd0, r_gain_i});
    assign w_accept = i_item.valid && i_item.ready;

    // Operand selection for the current step
    always_comb begin
        w_is_div = 1'b1;
        w_a      = r_t;
        w_b      = t_word'(K_MILLI);
        unique case (r_step)
            ST_LIM_MUL: begin
                w_is_div = 1'b0;
                w_a      = w_span;
                w_b      = t_word'(K_IDIV);
            end
            ST_LIM_DIV: w_b = w_gi;
            ST_FF_MUL: begin
                w_is_div = 1'b0;
                w_a      = W_WORD'(r_tgt);
                w_b      = t_word'({49'd0, r_ff_duty});
            end
            ST_FF_DIV: begin
                w_a = r_t + (w_ffmax >>> 1);
                w_b = w_ffmax;
            end
            ST_P_MUL: begin
                w_is_div = 1'b0;
                w_a      = t_word'({48'd0, r_gain_p});
                w_b      = W_WORD'(r_err);
            end
            ST_P_DIV: w_b = t_word'(K_MILLI);
            ST_R_MUL: begin
                w_is_div = 1'b0;
                w_a      = W_WORD'(r_meas) - W_WORD'(r_last);
                w_b      = t_word'(K_MILLI);
            end
            ST_R_DIV: w_b = w_per;
            ST_D_MUL: begin
                w_is_div = 1'b0;
                w_a      = t_word'({48'd0, r_gain_d});
                w_b      = r_t;
            end
            ST_D_DIV: w_a = -r_t;
            // 200*raw + 800*filtered as shifts and adds
            ST_F_DIV: begin
                w_a = (r_t <<< 7) + (r_t <<< 6) + (r_t <<< 3)
                    + (W_WORD'(r_df) <<< 9) + (W_WORD'(r_df) <<< 8)
                    + (W_WORD'(r_df) <<< 5);
            end
            ST_E_MUL: begin
                w_is_div = 1'b0;
                w_a      = W_WORD'(r_err);
                w_b      = w_per;
            end
            ST_CI_MUL: begin
                w_is_div = 1'b0;
                w_a      = w_gi;
                w_b      = W_WORD'(r_cand);
            end
            ST_CI_DIV: w_b = t_word'(K_IDIV);
            ST_I_MUL: begin
                w_is_div = 1'b0;
                w_a      = w_gi;
                w_b      = W_WORD'(r_ei);
            end
            ST_I_DIV: w_b = t_word'(K_IDIV);
            default:  w_b = t_word'(K_MILLI);
        endcase
    end

    assign w_req = '{start: w_start, is_div: w_is_div};

    pidsc_serial_unit u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_rsp    (w_rsp),
        .o_result (w_q)
    );

    assign w_sum     = W_WORD'(r_ff) + W_WORD'(r_p) + w_q + W_WORD'(r_df);
    assign w_lim_new = (r_gain_i == '0) ? t_word'(0) : w_q;
    assign w_ei_rc   = clamp_sym(W_WORD'(r_ei), w_lim_new);
    assign w_cand_cl = clamp_sym(W_WORD'(r_ei) + w_q, W_WORD'(r_lim));

    // Next state, step post-processing and handshakes
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_tgt       = r_tgt;
        n_meas      = r_meas;
        n_err       = r_err;
        n_last      = r_last;
        n_have_last = r_have_last;
        n_ei        = r_ei;
        n_df        = r_df;
        n_lim       = r_lim;
        n_cand      = r_cand;
        n_ff        = r_ff;
        n_p         = r_p;
        n_t         = r_t;
        n_res       = r_res;
        n_duty      = r_duty;
        n_ovalid    = r_ovalid && !o_result.ready;
        w_start     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.action) begin
                        n_last      = '0;
                        n_have_last = 1'b0;
                        n_ei        = '0;
                        n_df        = '0;
                        n_res       = '0;
                        n_state     = S_DONE;
                    end else begin
                        n_tgt   = i_item.target_speed;
                        n_meas  = i_item.measured_speed;
                        n_err   = (W_SPEED+1)'(i_item.target_speed)
                                  - (W_SPEED+1)'(i_item.measured_speed);
                        n_step  = ST_LIM_MUL;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                w_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_rsp.done) begin
                    n_t     = w_q;
                    n_step  = t_step'(r_step + 4'd1);
                    n_state = S_ISSUE;
                    case (r_step)
                        // Integral limit, then reclamp the stored integral
                        ST_LIM_DIV: begin
                            n_lim = w_lim_new[W_EI-1:0];
                            n_ei  = w_ei_rc[W_EI-1:0];
                        end
                        ST_FF_DIV: begin
                            n_ff = (r_tgt > 0 && r_ff_duty != '0)
                                 ? clamp_out(w_q, w_lo, w_hi) : '0;
                        end
                        // Skip the derivative on the first sample
                        ST_P_DIV: begin
                            n_p = w_q[W_PTERM-1:0];
                            if (!r_have_last) begin
                                n_df   = '0;
                                n_step = ST_E_MUL;
                            end
                        end
                        ST_F_DIV: n_df = w_q[W_DF-1:0];
                        ST_E_MUL: begin
                            n_cand = w_cand_cl[W_EI-1:0];
                        end
                        // Commit the integral unless it winds further into saturation
                        ST_CI_DIV: begin
                            if ((w_sum >= W_WORD'(w_lo) && w_sum <= W_WORD'(w_hi)) ||
                                (w_sum > W_WORD'(w_hi) && r_err < 0) ||
                                (w_sum < W_WORD'(w_lo) && r_err > 0)) begin
                                n_ei = r_cand;
                            end
                        end
                        ST_I_DIV: begin
                            n_res       = clamp_out(w_sum, w_lo, w_hi);
                            n_last      = r_meas;
                            n_have_last = 1'b1;
                            n_state     = S_DONE;
                        end
                        default: n_t = w_q;
                    endcase
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_result.ready) begin
                    n_ovalid = 1'b1;
                    n_duty   = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_LIM_MUL;
            r_ovalid    <= 1'b0;
            r_last      <= '0;
            r_have_last <= 1'b0;
            r_ei        <= '0;
            r_df        <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_ovalid    <= n_ovalid;
            r_last      <= n_last;
            r_have_last <= n_have_last;
            r_ei        <= n_ei;
            r_df        <= n_df;
        end
        r_tgt  <= n_tgt;
        r_meas <= n_meas;
        r_err  <= n_err;
        r_lim  <= n_lim;
        r_cand <= n_cand;
        r_ff   <= n_ff;
        r_p    <= n_p;
        r_t    <= n_t;
        r_res  <= n_res;
        r_duty <= n_duty;
    end

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_ovalid;
    assign o_result.duty  = r_duty;

    // The arithmetic unit is only started when it is free
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("serial unit started while busy");

    // A clear transaction empties the controller state
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.action) |=> (!r_have_last && r_ei == '0 && r_df == '0))
        else $error("clear left state behind");

    // A finished transaction has either taken a sample or left the state empty
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_have_last || (r_ei == '0 && r_df == '0)))
        else $error("inconsistent state at end of transaction");

endmodule
